>>> hw/rtl/hnlr_pkg.sv
// ----------------------------------------------------------------------------
// hnlr_pkg: shared types and constants for the held-note root tracker
// Token carried along the cell chain, controller states, operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hnlr_pkg;

  localparam int VOICE_W = 32;
  localparam int PITCH_W = 7;
  localparam int NOTE_W  = 9;

  // root reported after reset until a note is held
  localparam logic [PITCH_W-1:0] FALLBACK_RESET = 7'd36;

  // operation codes of the input transaction
  localparam logic OP_NOTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } hnlr_state_t;

  // scan token, handed from cell to cell once per cycle
  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [PITCH_W-1:0] pitch;
    logic               note_on;
    logic               phase2;      // 0: match pass, 1: fill and minimum pass
    logic               hit;         // a matching entry was found
    logic               any_free;    // a free entry was seen in the match pass
    logic               fill_done;   // the new voice has been written
    logic               force_first; // table full: first cell takes the voice
    logic               min_any;
    logic [PITCH_W-1:0] min_pitch;
  } hnlr_tok_t;

endpackage

`default_nettype wire

>>> hw/rtl/hnlr_in_if.sv
// ----------------------------------------------------------------------------
// hnlr_in_if: input event channel
// Valid/ready channel carrying one harmony event or clear command.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnlr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [hnlr_pkg::VOICE_W-1:0]        voice_id;
  logic signed [hnlr_pkg::NOTE_W-1:0]  note;
  logic                                note_on;
  logic                                bend_update;

  modport source (output valid, output op, output voice_id, output note,
                  output note_on, output bend_update, input ready);
  modport sink   (input valid, input op, input voice_id, input note,
                  input note_on, input bend_update, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hnlr_out_if.sv
// ----------------------------------------------------------------------------
// hnlr_out_if: result channel
// Valid/ready channel carrying the current root after each event.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnlr_out_if;
  logic                         valid;
  logic                         ready;
  logic [hnlr_pkg::PITCH_W-1:0] root;
  logic                         root_valid;

  modport source (output valid, output root, output root_valid, input ready);
  modport sink   (input valid, input root, input root_valid, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hnlr_cell.sv
// ----------------------------------------------------------------------------
// hnlr_cell: one table entry of the held-note chain
// Holds one voice/pitch entry, updates it from the passing token and
// registers the token for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hnlr_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clr,
  input  wire logic                in_valid,
  input  wire hnlr_pkg::hnlr_tok_t in_tok,
  output logic                     out_valid,
  output hnlr_pkg::hnlr_tok_t      out_tok
);

  logic                                 used_r, used_nxt;
  logic [hnlr_pkg::VOICE_W-1:0]         voice_r, voice_nxt;
  logic [hnlr_pkg::PITCH_W-1:0]         pitch_r, pitch_nxt;
  logic                                 tok_valid_r;
  hnlr_pkg::hnlr_tok_t                  tok_r, tok_nxt;
  logic                                 wr_fill;

  // entry update and token rewrite
  always_comb begin
    tok_nxt   = in_tok;
    used_nxt  = used_r;
    voice_nxt = voice_r;
    pitch_nxt = pitch_r;
    wr_fill   = 1'b0;
    if (in_valid) begin
      if (!in_tok.phase2) begin
        // match pass: first matching entry takes the event
        if (used_r && (voice_r == in_tok.voice) && !in_tok.hit) begin
          tok_nxt.hit = 1'b1;
          if (in_tok.note_on) begin
            pitch_nxt = in_tok.pitch;
          end else begin
            used_nxt = 1'b0;
          end
        end
        if (!used_r) begin
          tok_nxt.any_free = 1'b1;
        end
      end else begin
        // fill pass: new voice goes to the first free entry (the first cell if full), then minimum
        wr_fill = !in_tok.hit && in_tok.note_on && !in_tok.fill_done &&
                  (!used_r || in_tok.force_first);
        if (wr_fill) begin
          used_nxt          = 1'b1;
          voice_nxt         = in_tok.voice;
          pitch_nxt         = in_tok.pitch;
          tok_nxt.fill_done = 1'b1;
        end
        tok_nxt.force_first = 1'b0;
        if (used_nxt && (!in_tok.min_any || (pitch_nxt < in_tok.min_pitch))) begin
          tok_nxt.min_any   = 1'b1;
          tok_nxt.min_pitch = pitch_nxt;
        end
      end
    end
    if (clr) begin
      used_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      tok_valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    voice_r <= voice_nxt;
    pitch_r <= pitch_nxt;
    tok_r   <= tok_nxt;
  end

  assign out_valid = tok_valid_r;
  assign out_tok   = tok_r;

endmodule

`default_nettype wire

>>> hw/rtl/held_note_lowest_root_tracker.sv
// Sequence: a note event runs from acceptance through the match pass, the fill
// and minimum pass, ST_APPLY and ST_DONE; an ignored event or a clear goes
// straight to ST_DONE. One transaction at a time; the next is accepted the
// cycle after the result is loaded, and a result still waiting in the output
// register holds the controller in ST_DONE until the sink takes it.
// Reset (synchronous, active low) empties the table and loads fallback 36.
// ----------------------------------------------------------------------------
// held_note_lowest_root_tracker: lowest held note as live root
// Chain of entry cells scanned by a token: a match pass, then a fill and
// minimum pass; the controller sequences passes and holds the root.
// ----------------------------------------------------------------------------
`default_nettype none

module held_note_lowest_root_tracker #(
  parameter int ENTRIES = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  hnlr_in_if.sink                           in_ch,
  hnlr_out_if.source                        out_ch,
  input  wire logic                         cfg_wr_en,
  input  wire logic [hnlr_pkg::PITCH_W-1:0] cfg_wr_data
);

  hnlr_pkg::hnlr_state_t        state_r, state_nxt;
  logic [hnlr_pkg::PITCH_W-1:0] fallback_r;
  logic [hnlr_pkg::PITCH_W-1:0] live_root_r, live_root_nxt;
  logic                         root_seen_r, root_seen_nxt;
  logic                         launch_valid_r, launch_valid_nxt;
  hnlr_pkg::hnlr_tok_t          launch_tok_r, launch_tok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hnlr_pkg::PITCH_W-1:0] out_root_r, out_root_nxt;
  logic                         out_root_valid_r, out_root_valid_nxt;

  logic                         accept;
  logic                         note_ok;
  logic                         cell_clr;
  logic                         ret_valid;
  hnlr_pkg::hnlr_tok_t          ret_tok;

  logic [ENTRIES:0]             link_valid;
  hnlr_pkg::hnlr_tok_t          link_tok [ENTRIES+1];

  // input decode
  assign in_ch.ready = (state_r == hnlr_pkg::ST_IDLE);
  assign accept  = in_ch.valid && in_ch.ready;
  assign note_ok = (in_ch.op == hnlr_pkg::OP_NOTE) && !in_ch.bend_update &&
                   (in_ch.note[hnlr_pkg::NOTE_W-1:hnlr_pkg::PITCH_W] == 2'b00);
  assign cell_clr = accept && (in_ch.op == hnlr_pkg::OP_CLEAR);

  // cell chain
  assign link_valid[0] = launch_valid_r;
  assign link_tok[0]   = launch_tok_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    hnlr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (cell_clr),
      .in_valid  (link_valid[g]),
      .in_tok    (link_tok[g]),
      .out_valid (link_valid[g+1]),
      .out_tok   (link_tok[g+1])
    );
  end

  assign ret_valid = link_valid[ENTRIES];
  assign ret_tok   = link_tok[ENTRIES];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hnlr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = note_ok ? hnlr_pkg::ST_SCAN : hnlr_pkg::ST_DONE;
        end
      end
      hnlr_pkg::ST_SCAN: begin
        if (ret_valid) begin
          state_nxt = hnlr_pkg::ST_APPLY;
        end
      end
      hnlr_pkg::ST_APPLY: begin
        if (ret_valid) begin
          state_nxt = hnlr_pkg::ST_DONE;
        end
      end
      hnlr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = hnlr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hnlr_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    live_root_nxt      = live_root_r;
    root_seen_nxt      = root_seen_r;
    launch_valid_nxt   = 1'b0;
    launch_tok_nxt     = launch_tok_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_root_nxt       = out_root_r;
    out_root_valid_nxt = out_root_valid_r;
    case (state_r)
      hnlr_pkg::ST_IDLE: begin
        if (cell_clr) begin
          root_seen_nxt = 1'b0;
          live_root_nxt = fallback_r;
        end else if (accept && note_ok) begin
          launch_valid_nxt           = 1'b1;
          launch_tok_nxt             = '0;
          launch_tok_nxt.voice       = in_ch.voice_id;
          launch_tok_nxt.pitch       = in_ch.note[hnlr_pkg::PITCH_W-1:0];
          launch_tok_nxt.note_on     = in_ch.note_on;
        end
      end
      hnlr_pkg::ST_SCAN: begin
        // match pass back: relaunch for the fill and minimum pass
        if (ret_valid) begin
          launch_valid_nxt           = 1'b1;
          launch_tok_nxt             = ret_tok;
          launch_tok_nxt.phase2      = 1'b1;
          launch_tok_nxt.fill_done   = 1'b0;
          launch_tok_nxt.force_first = !ret_tok.any_free;
          launch_tok_nxt.min_any     = 1'b0;
        end
      end
      hnlr_pkg::ST_APPLY: begin
        if (ret_valid && ret_tok.min_any) begin
          live_root_nxt = ret_tok.min_pitch;
          root_seen_nxt = 1'b1;
        end
      end
      hnlr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt      = 1'b1;
          out_root_nxt       = root_seen_r ? live_root_r : fallback_r;
          out_root_valid_nxt = root_seen_r;
        end
      end
      default: begin
        launch_valid_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hnlr_pkg::ST_IDLE;
      fallback_r     <= hnlr_pkg::FALLBACK_RESET;
      live_root_r    <= hnlr_pkg::FALLBACK_RESET;
      root_seen_r    <= 1'b0;
      launch_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) begin
        fallback_r   <= cfg_wr_data;
      end
      live_root_r    <= live_root_nxt;
      root_seen_r    <= root_seen_nxt;
      launch_valid_r <= launch_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    launch_tok_r     <= launch_tok_nxt;
    out_root_r       <= out_root_nxt;
    out_root_valid_r <= out_root_valid_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.root       = out_root_r;
  assign out_ch.root_valid = out_root_valid_r;

`ifndef SYNTHESIS
  // only one token is ever in flight along the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(link_valid) <= 1)
    else $error("more than one scan token in the cell chain");

  // a token leaves the chain only while a pass is running
  a_ret_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    ret_valid |-> (state_r == hnlr_pkg::ST_SCAN || state_r == hnlr_pkg::ST_APPLY))
    else $error("scan token returned outside a pass");

  // a clear leaves no root held
  a_clear_root: assert property (@(posedge clk) disable iff (!rst_n)
    cell_clr |=> !root_seen_r)
    else $error("root still held after clear");

  // a note event launches the match pass next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && note_ok) |=> (launch_valid_r && !launch_tok_r.phase2))
    else $error("note event did not launch the match pass");
`endif

endmodule

`default_nettype wire
